### hw/rtl/pba_pkg.sv
package pba_pkg;

   // Geometry of the page map.
   localparam int PAGE_COUNT = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_BITS  = 32;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = PAGE_COUNT / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(MAP_WORDS);
   localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
   localparam int FREE_W     = $clog2(PAGE_COUNT + 1);

   // Fixed payload widths.
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 32;
   localparam int PADDR_W = 24;
   localparam int CNT_W   = 13;

   typedef enum logic [OP_W-1:0] {
      OP_MARK_USED = 2'd0,
      OP_MARK_FREE = 2'd1,
      OP_ALLOCATE  = 2'd2,
      OP_COUNT     = 2'd3
   } op_type;

endpackage

### hw/rtl/page_bitmap_allocator_top.sv
// Bitmap page-frame allocator. One bit per page frame (set means used) is kept in a
// 128 x 32-bit map memory that comes out of reset as all used. Every request transfer
// produces exactly one response transfer. Mark-used and mark-free take a byte address
// and byte length, round the length up to whole pages and clip at the end of memory; a
// start address at or past the end of memory changes nothing. Allocate takes the lowest
// free page and returns its byte address with found set. Count only reports. Every
// response carries the free page count after the operation. The block works on one
// request at a time and drops req_ready until its response is loaded. The single map
// memory port is used for one word at a time: each visited map word is first read, then
// modified and written back. Count visits no word, a range operation visits each word
// that it touches, and allocate visits words from the first up to the first word with a
// free page, at most all 128. No clearing pass is needed after reset: a per-word valid
// bit makes unwritten map words read as all used.
module page_bitmap_allocator_top
   import pba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic [LEN_W-1:0]   req_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [PADDR_W-1:0] rsp_page_address,
   output logic [CNT_W-1:0]   rsp_free_pages
);

   localparam int SPAN_W = LEN_W - PAGE_SHIFT + 1;
   localparam int SUM_W  = (SPAN_W > PAGE_IDX_W ? SPAN_W : PAGE_IDX_W) + 1;
   localparam logic [ADDR_W:0] MEM_END = (ADDR_W + 1)'(PAGE_COUNT) << PAGE_SHIFT;
   localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   op_type                  op_ff;
   logic [WORD_IDX_W-1:0]   word_ff;
   logic [PAGE_IDX_W-1:0]   first_ff;
   logic [PAGE_IDX_W-1:0]   last_ff;
   logic [FREE_W-1:0]       free_ff;
   logic                    found_ff;
   logic [PAGE_IDX_W-1:0]   page_ff;
   logic [MAP_WORDS-1:0]    row_valid_ff;
   logic                    rd_valid_ff;
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic [PADDR_W-1:0]      rsp_paddr_ff;
   logic [CNT_W-1:0]        rsp_free_ff;

   // The map memory.
   logic [WORD_BITS-1:0]    map_mem [MAP_WORDS];

   // Request decode, done in the idle state.
   logic                    addr_ok;
   logic [PAGE_IDX_W-1:0]   first_page;
   logic [SPAN_W-1:0]       span;
   logic [SUM_W-1:0]        end_raw;
   logic [SUM_W-1:0]        end_clip;
   logic                    range_empty;
   logic [PAGE_IDX_W-1:0]   last_page;

   // Word modify path.
   logic [WORD_BITS-1:0]    cur_word;
   logic [BIT_IDX_W-1:0]    lo_bit;
   logic [BIT_IDX_W-1:0]    hi_bit;
   logic [WORD_BITS-1:0]    range_mask;
   logic [WORD_BITS-1:0]    changed;
   logic [BIT_IDX_W:0]      changed_cnt;
   logic [BIT_IDX_W-1:0]    zero_bit;
   logic                    has_zero;
   logic [WORD_BITS-1:0]    new_word;
   logic                    mem_we;
   logic [PAGE_IDX_W+PAGE_SHIFT-1:0] paddr_wide;

   function automatic logic [BIT_IDX_W:0] popcount(input logic [WORD_BITS-1:0] value);
      logic [BIT_IDX_W:0] sum;
      sum = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         sum = sum + (BIT_IDX_W + 1)'(value[i]);
      end
      return sum;
   endfunction

   always_comb begin
      addr_ok     = {1'b0, req_address} < MEM_END;
      first_page  = req_address[PAGE_SHIFT +: PAGE_IDX_W];
      span        = {1'b0, req_length[LEN_W-1:PAGE_SHIFT]}
                    + SPAN_W'(|req_length[PAGE_SHIFT-1:0]);
      end_raw     = SUM_W'(first_page) + SUM_W'(span);
      end_clip    = (end_raw > SUM_W'(PAGE_COUNT)) ? SUM_W'(PAGE_COUNT) : end_raw;
      range_empty = (span == '0) || !addr_ok;
      last_page   = PAGE_IDX_W'(end_clip - SUM_W'(1));
   end

   // An unwritten map word still holds its reset value: every page used.
   assign cur_word = rd_valid_ff ? rd_data_ff : FULL_WORD;

   always_comb begin
      lo_bit = (word_ff == first_ff[PAGE_IDX_W-1:BIT_IDX_W]) ?
               first_ff[BIT_IDX_W-1:0] : '0;
      hi_bit = (word_ff == last_ff[PAGE_IDX_W-1:BIT_IDX_W]) ?
               last_ff[BIT_IDX_W-1:0] : '1;
      range_mask = (FULL_WORD << lo_bit) & (FULL_WORD >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit));
      changed    = (op_ff == OP_MARK_USED) ? (range_mask & ~cur_word) : (range_mask & cur_word);
      changed_cnt = popcount(changed);

      // Lowest clear bit of the current word.
      has_zero = 1'b0;
      zero_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!cur_word[i]) begin
            has_zero = 1'b1;
            zero_bit = BIT_IDX_W'(i);
         end
      end

      new_word = cur_word;
      mem_we   = 1'b0;
      if (state_ff == ST_MODIFY) begin
         case (op_ff)
            OP_MARK_USED: begin
               new_word = cur_word | range_mask;
               mem_we   = 1'b1;
            end
            OP_MARK_FREE: begin
               new_word = cur_word & ~range_mask;
               mem_we   = 1'b1;
            end
            OP_ALLOCATE: begin
               new_word = cur_word | (WORD_BITS'(1) << zero_bit);
               mem_we   = has_zero;
            end
            default: begin
               new_word = cur_word;
               mem_we   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[word_ff] <= new_word;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= map_mem[word_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_COUNT;
         word_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         free_ff      <= '0;
         found_ff     <= 1'b0;
         page_ff      <= '0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_paddr_ff <= '0;
         rsp_free_ff  <= '0;
      end else begin
         // In the finish state the response load below owns the valid flag.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= op_type'(req_operation);
                  found_ff <= 1'b0;
                  page_ff  <= '0;
                  first_ff <= first_page;
                  last_ff  <= last_page;
                  case (op_type'(req_operation))
                     OP_MARK_USED, OP_MARK_FREE: begin
                        word_ff  <= first_page[PAGE_IDX_W-1:BIT_IDX_W];
                        state_ff <= range_empty ? ST_FINISH : ST_READ;
                     end
                     OP_ALLOCATE: begin
                        word_ff  <= '0;
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rd_valid_ff <= row_valid_ff[word_ff];
               state_ff    <= ST_MODIFY;
            end
            ST_MODIFY: begin
               if (mem_we) begin
                  row_valid_ff[word_ff] <= 1'b1;
               end
               if (op_ff == OP_ALLOCATE) begin
                  if (has_zero) begin
                     free_ff  <= free_ff - FREE_W'(1);
                     found_ff <= 1'b1;
                     page_ff  <= {word_ff, zero_bit};
                     state_ff <= ST_FINISH;
                  end else if (word_ff == WORD_IDX_W'(MAP_WORDS - 1)) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     word_ff  <= word_ff + WORD_IDX_W'(1);
                     state_ff <= ST_READ;
                  end
               end else begin
                  if (op_ff == OP_MARK_USED) begin
                     free_ff <= free_ff - FREE_W'(changed_cnt);
                  end else begin
                     free_ff <= free_ff + FREE_W'(changed_cnt);
                  end
                  if (word_ff == last_ff[PAGE_IDX_W-1:BIT_IDX_W]) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     word_ff  <= word_ff + WORD_IDX_W'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FINISH: begin
               // The response register is loaded once any earlier response has gone.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_paddr_ff <= found_ff ? PADDR_W'(paddr_wide) : '0;
                  rsp_free_ff  <= CNT_W'(free_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign paddr_wide = {page_ff, {PAGE_SHIFT{1'b0}}};

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_page_address = rsp_paddr_ff;
   assign rsp_free_pages   = rsp_free_ff;

`ifndef SYNTHESIS
   // The free count can never pass the number of pages.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(PAGE_COUNT))
      else $error("free page count exceeds page count");

   // Once a request is taken the block stops taking more until it responds.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A successful allocation takes exactly one page off the free count.
   a_alloc_decrements: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY && op_ff == OP_ALLOCATE && has_zero
      |=> free_ff == $past(free_ff) - FREE_W'(1))
      else $error("allocation did not take one free page");

   // A found response always names a page inside memory.
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> {1'b0, rsp_page_address} < 25'(MEM_END))
      else $error("allocated page lies past the end of memory");
`endif

endmodule
